FILE: rtl/core/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and record layout for the protecting distance replacement block.
// ----------------------------------------------------------------------------
package pdr_pkg;

  typedef enum logic [1:0] {
    OP_HIT    = 2'd0,
    OP_FILL   = 2'd1,
    OP_VICTIM = 2'd2,
    OP_INVAL  = 2'd3
  } opcode_e;

  // configuration registers
  localparam int unsigned NUM_PD_REGS = 4;
  localparam int unsigned PD_IDX_W    = 2;
  localparam int unsigned PD_W        = 9;

  // field widths of the transactions
  localparam int unsigned SET_IDX_W = 10;
  localparam int unsigned WAY_IDX_W = 4;
  localparam int unsigned CPU_IDX_W = 2;
  localparam int unsigned VICTIM_W  = 4;

  // way record layout, distance counter sits on top
  localparam int unsigned REC_VALID    = 0;
  localparam int unsigned REC_REF      = 1;
  localparam int unsigned REC_IP       = 2;
  localparam int unsigned REC_PROT     = 3;
  localparam int unsigned REC_ORIG_LSB = 4;
  localparam int unsigned REC_DIST_LSB = REC_ORIG_LSB + PD_W;

  typedef struct packed {
    opcode_e         op;
    logic            from_ip;
    logic [PD_W-1:0] pd;
  } upd_cmd_t;

  typedef struct packed {
    logic                done;
    logic                was_invalid;
    logic [VICTIM_W-1:0] way;
  } scan_res_t;

endpackage

FILE: rtl/core/pdr_row_mem.sv
// ----------------------------------------------------------------------------
// pdr_row_mem
// Set row store: one write and one registered read per cycle, zeroed by a
// sweep after reset.
// ----------------------------------------------------------------------------
module pdr_row_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 368,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o,
  output logic             init_done_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_busy_q, clr_busy_d;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = !clr_busy_q;

endmodule

FILE: rtl/core/pdr_row_update.sv
// ----------------------------------------------------------------------------
// pdr_row_update
// Applies hit, fill or invalidate to one way of a set row, then ages the
// whole row on a fill.
// ----------------------------------------------------------------------------
module pdr_row_update #(
  parameter int unsigned NumWays     = 16,
  parameter int unsigned MaxDistance = 256,
  parameter int unsigned DistW       = 10,
  parameter int unsigned WayW        = 4,
  parameter int unsigned RowW        = 368
) (
  input  logic [RowW-1:0]   row_i,
  input  pdr_pkg::upd_cmd_t cmd_i,
  input  logic [WayW-1:0]   way_i,
  output logic [RowW-1:0]   row_o
);

  import pdr_pkg::*;

  localparam int unsigned RecW = REC_DIST_LSB + DistW;

  always_comb begin
    logic             valid;
    logic             refb;
    logic             ipb;
    logic             prot;
    logic [PD_W-1:0]  orig;
    logic [DistW-1:0] rdist;
    row_o = row_i;
    for (int w = 0; w < NumWays; w++) begin
      valid = row_i[w*RecW + REC_VALID];
      refb  = row_i[w*RecW + REC_REF];
      ipb   = row_i[w*RecW + REC_IP];
      prot  = row_i[w*RecW + REC_PROT];
      orig  = row_i[w*RecW + REC_ORIG_LSB +: PD_W];
      rdist = row_i[w*RecW + REC_DIST_LSB +: DistW];

      if (WayW'(w) == way_i) begin
        unique case (cmd_i.op)
          OP_HIT: begin
            if (ipb) begin
              prot = 1'b0;
            end else begin
              prot  = 1'b1;
              rdist = DistW'(orig);
              refb  = 1'b1;
            end
          end
          OP_FILL: begin
            valid = 1'b1;
            if (cmd_i.from_ip) begin
              ipb  = 1'b1;
              prot = 1'b1;
            end else begin
              ipb   = 1'b0;
              prot  = 1'b0;
              rdist = DistW'(cmd_i.pd);
              orig  = cmd_i.pd;
            end
            refb = 1'b0;
          end
          OP_INVAL: begin
            valid = 1'b0;
          end
          default: begin
          end
        endcase
      end

      // aging of every way, a counter at one or zero reloads
      if (cmd_i.op == OP_FILL) begin
        if (rdist < DistW'(2)) begin
          rdist = DistW'(MaxDistance) + DistW'(orig);
          prot  = 1'b0;
        end else begin
          rdist = rdist - DistW'(1);
        end
      end

      row_o[w*RecW +: RecW] = {rdist, orig, prot, ipb, refb, valid};
    end
  end

endmodule

FILE: rtl/core/pdr_victim_scan.sv
// ----------------------------------------------------------------------------
// pdr_victim_scan
// Walks the ways of a set row one per cycle and picks the replacement victim.
// ----------------------------------------------------------------------------
module pdr_victim_scan #(
  parameter int unsigned NumWays = 16,
  parameter int unsigned DistW   = 10,
  parameter int unsigned WayW    = 4,
  parameter int unsigned RowW    = 368
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RowW-1:0]    row_i,
  output pdr_pkg::scan_res_t res_o
);

  import pdr_pkg::*;

  localparam int unsigned RecW = REC_DIST_LSB + DistW;
  localparam int unsigned ExtW = (WayW > VICTIM_W) ? WayW : VICTIM_W;

  logic [WayW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             inv_found_q, inv_found_d;
  logic [WayW-1:0]  inv_way_q, inv_way_d;
  logic             u_found_q, u_found_d;
  logic [DistW-1:0] u_best_q, u_best_d;
  logic [WayW-1:0]  u_way_q, u_way_d;
  logic [DistW-1:0] a_best_q, a_best_d;
  logic [WayW-1:0]  a_way_q, a_way_d;

  logic [RecW-1:0]  rec;
  logic             rec_valid;
  logic             rec_prot;
  logic [DistW-1:0] rec_dist;
  logic [WayW-1:0]  sel_way;
  logic [ExtW-1:0]  sel_ext;

  assign rec       = row_i[cnt_q*RecW +: RecW];
  assign rec_valid = rec[REC_VALID];
  assign rec_prot  = rec[REC_PROT];
  assign rec_dist  = rec[REC_DIST_LSB +: DistW];

  always_comb begin
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    done_d      = done_q;
    inv_found_d = inv_found_q;
    inv_way_d   = inv_way_q;
    u_found_d   = u_found_q;
    u_best_d    = u_best_q;
    u_way_d     = u_way_q;
    a_best_d    = a_best_q;
    a_way_d     = a_way_q;
    if (start_i) begin
      cnt_d       = '0;
      busy_d      = 1'b1;
      done_d      = 1'b0;
      inv_found_d = 1'b0;
      inv_way_d   = '0;
      u_found_d   = 1'b0;
      u_best_d    = '0;
      u_way_d     = '0;
      a_best_d    = '0;
      a_way_d     = '0;
    end else if (busy_q) begin
      if (!rec_valid && !inv_found_q) begin
        inv_found_d = 1'b1;
        inv_way_d   = cnt_q;
      end
      if (!rec_prot && (rec_dist > u_best_q)) begin
        u_found_d = 1'b1;
        u_best_d  = rec_dist;
        u_way_d   = cnt_q;
      end
      if (rec_dist > a_best_q) begin
        a_best_d = rec_dist;
        a_way_d  = cnt_q;
      end
      cnt_d = cnt_q + WayW'(1);
      if (cnt_q == WayW'(NumWays - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_found_q <= inv_found_d;
    inv_way_q   <= inv_way_d;
    u_found_q   <= u_found_d;
    u_best_q    <= u_best_d;
    u_way_q     <= u_way_d;
    a_best_q    <= a_best_d;
    a_way_q     <= a_way_d;
  end

  // invalid way first, then unprotected, then any; way 0 when all are zero
  assign sel_way = inv_found_q ? inv_way_q : (u_found_q ? u_way_q : a_way_q);
  assign sel_ext = ExtW'(sel_way);

  assign res_o.done        = done_q;
  assign res_o.was_invalid = inv_found_q;
  assign res_o.way         = sel_ext[VICTIM_W-1:0];

endmodule

FILE: rtl/core/protecting_distance_replacement.sv
// ----------------------------------------------------------------------------
// protecting_distance_replacement
// Protecting distance replacement state for a set-associative cache: hit,
// fill, victim search and invalidate on a per-set row store.
// ----------------------------------------------------------------------------
//  channel   direction  fields (lowest bit first)
//  s_axis    in         tdata: set_index, way_index, from_ip, cpu_index
//                       tuser: opcode
//  m_axis    out        tdata: victim_way, victim_was_invalid, op_done
//  cfg       in         cfg_idx_i selects pd_cpu0..pd_cpu3, written when cfg_we_i
//
//  hit, fill and invalidate go through accept, row read, modify and write back
//  find victim reads the row, then the victim scan walks one way per cycle
//  one transaction is in flight at a time; the row store has a single read port
//  after reset a clearing pass over every set runs before the first accept
//  a result waiting on m_axis does not block the next accept, only the next finish
// ----------------------------------------------------------------------------
module protecting_distance_replacement #(
  parameter int unsigned NUM_SETS     = 1024,
  parameter int unsigned NUM_WAYS     = 16,
  parameter int unsigned MAX_DISTANCE = 256,
  parameter int unsigned NUM_CPUS     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // set_index[9:0], way_index[13:10], from_ip[14], cpu_index[16:15], zero pad
  input  logic [23:0]                   s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // victim_way[3:0], victim_was_invalid[4], op_done[5], zero pad
  output logic [7:0]                    m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::PD_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdr_pkg::PD_W-1:0]      cfg_data_i
);

  import pdr_pkg::*;

  localparam int unsigned RowAW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned RemW    = (RowAW > SET_IDX_W) ? RowAW : SET_IDX_W;
  localparam int unsigned WayW    = $clog2(NUM_WAYS);
  localparam int unsigned DistW   = $clog2(MAX_DISTANCE + (1 << PD_W));
  localparam int unsigned RecW    = REC_DIST_LSB + DistW;
  localparam int unsigned RowBits = NUM_WAYS * RecW;

  // set index wrap: quotient by reciprocal, exact for set indexes below 2**10
  localparam int unsigned DivShift = 2 * SET_IDX_W;
  localparam logic [DivShift:0] DivMul = (DivShift + 1)'((1 << DivShift) / NUM_SETS + 1);
  localparam int unsigned ProdW   = SET_IDX_W + DivShift + 1;
  localparam int unsigned QnW     = SET_IDX_W + 17;

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_ADDR = 5'b00100,
    S_EXEC = 5'b01000,
    S_SCAN = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [PD_W-1:0]      pd_q [NUM_PD_REGS];
  opcode_e              op_q;
  logic [SET_IDX_W-1:0] set_q;
  logic [WAY_IDX_W-1:0] way_q;
  logic                 ip_q;
  logic [CPU_IDX_W-1:0] cpu_q;
  logic [SET_IDX_W-1:0] quo_q, quo_d;
  logic [RowAW-1:0]     row_q, row_d;

  logic                 m_valid_q, m_valid_d;
  logic [VICTIM_W-1:0]  out_way_q;
  logic                 out_inv_q;
  logic                 out_load;
  logic [VICTIM_W-1:0]  out_way_d;
  logic                 out_inv_d;
  logic                 out_free;

  logic                 in_acc;
  logic [ProdW-1:0]     prod;
  logic [QnW-1:0]       qn;
  logic [SET_IDX_W-1:0] rem;
  logic [RemW-1:0]      rem_ext;
  logic [6:0]           way_ext;
  logic                 way_ok;
  logic [CPU_IDX_W-1:0] cpu_sat;

  logic                 mem_we;
  logic                 mem_re;
  logic [RowBits-1:0]   mem_rdata;
  logic [RowBits-1:0]   row_new;
  logic                 init_done;
  logic                 scan_start;
  upd_cmd_t             upd_cmd;
  scan_res_t            scan_res;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // quotient for the set wrap, taken at accept
  assign prod  = ProdW'(s_axis_tdata[SET_IDX_W-1:0]) * ProdW'(DivMul);
  assign quo_d = prod[DivShift +: SET_IDX_W];

  assign qn      = QnW'(quo_q) * QnW'(NUM_SETS);
  assign rem     = set_q - qn[SET_IDX_W-1:0];
  assign rem_ext = RemW'(rem);
  assign row_d   = rem_ext[RowAW-1:0];

  assign way_ext = 7'(way_q);
  assign way_ok  = way_ext < 7'(NUM_WAYS);
  assign cpu_sat = ({1'b0, cpu_q} < (CPU_IDX_W + 1)'(NUM_CPUS)) ?
                   cpu_q : CPU_IDX_W'(NUM_CPUS - 1);

  assign upd_cmd.op      = op_q;
  assign upd_cmd.from_ip = ip_q;
  assign upd_cmd.pd      = pd_q[cpu_sat];

  always_comb begin
    state_d    = state_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    out_way_d  = '0;
    out_inv_d  = 1'b0;
    unique case (state_q)
      S_INIT: begin
        if (init_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        mem_re  = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (op_q == OP_VICTIM) begin
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end else if (out_free) begin
          mem_we   = way_ok;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_res.done && out_free) begin
          out_load  = 1'b1;
          out_way_d = scan_res.way;
          out_inv_d = scan_res.was_invalid;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PD_REGS; i++) begin
        pd_q[i] <= PD_W'(1);
      end
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        pd_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_e'(s_axis_tuser);
      set_q <= s_axis_tdata[SET_IDX_W-1:0];
      way_q <= s_axis_tdata[SET_IDX_W +: WAY_IDX_W];
      ip_q  <= s_axis_tdata[SET_IDX_W + WAY_IDX_W];
      cpu_q <= s_axis_tdata[SET_IDX_W + WAY_IDX_W + 1 +: CPU_IDX_W];
      quo_q <= quo_d;
    end
    if (state_q == S_ADDR) begin
      row_q <= row_d;
    end
    if (out_load) begin
      out_way_q <= out_way_d;
      out_inv_q <= out_inv_d;
    end
  end

  pdr_row_mem #(
    .Depth (NUM_SETS),
    .Width (RowBits),
    .AddrW (RowAW)
  ) u_row_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (mem_we),
    .waddr_i     (row_q),
    .wdata_i     (row_new),
    .re_i        (mem_re),
    .raddr_i     (row_d),
    .rdata_o     (mem_rdata),
    .init_done_o (init_done)
  );

  pdr_row_update #(
    .NumWays     (NUM_WAYS),
    .MaxDistance (MAX_DISTANCE),
    .DistW       (DistW),
    .WayW        (WayW),
    .RowW        (RowBits)
  ) u_row_update (
    .row_i (mem_rdata),
    .cmd_i (upd_cmd),
    .way_i (way_ext[WayW-1:0]),
    .row_o (row_new)
  );

  pdr_victim_scan #(
    .NumWays (NUM_WAYS),
    .DistW   (DistW),
    .WayW    (WayW),
    .RowW    (RowBits)
  ) u_victim_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .row_i   (mem_rdata),
    .res_o   (scan_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, 1'b1, out_inv_q, out_way_q};

  // no transaction is taken before the clearing pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> init_done)
    else $error("input taken during clearing pass");

  // an accepted transaction always goes on to read its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_ADDR))
    else $error("accepted transaction did not issue a row read");

  // a victim search never writes the row store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("row write during victim scan");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten");

  // the result of a write-back operation shows in the cycle after the write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (m_axis_tvalid && (out_way_q == '0) && !out_inv_q))
    else $error("write-back without its result");

endmodule

FILE: tb/sv/tb_protecting_distance_replacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_protecting_distance_replacement
// Self-checking bench for the protecting distance replacement block. A queue
// of cache accesses feeds a stream driver; every accepted access updates a
// per-way shadow of the row store and queues the predicted reply, which the
// monitor compares field by field. Runs four distance settings under
// different idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_protecting_distance_replacement;
  import pdr_pkg::*;

  localparam int unsigned N_SETS         = 1024;
  localparam int unsigned N_WAYS         = 16;
  localparam int unsigned MAX_DIST       = 256;
  localparam int unsigned N_CPUS         = 4;
  localparam int unsigned SETTLE_CYCLES  = N_WAYS + 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned PHASE_ITEMS    = 320;

  localparam logic [PD_IDX_W-1:0] PD_CPU0_IDX = 2'd0;
  localparam logic [PD_IDX_W-1:0] PD_CPU1_IDX = 2'd1;
  localparam logic [PD_IDX_W-1:0] PD_CPU2_IDX = 2'd2;
  localparam logic [PD_IDX_W-1:0] PD_CPU3_IDX = 2'd3;

  typedef struct packed {
    opcode_e              op;
    logic [SET_IDX_W-1:0] set_idx;
    logic [WAY_IDX_W-1:0] way;
    logic                 from_ip;
    logic [CPU_IDX_W-1:0] cpu;
  } access_t;

  typedef struct packed {
    logic                done;
    logic                was_invalid;
    logic [VICTIM_W-1:0] way;
  } reply_t;

  // one way of the shadow row store, distance can reach MAX_DIST + 511
  typedef struct packed {
    logic            valid;
    logic            prot;
    logic            ip;
    logic            refb;
    logic [9:0]      rdist;
    logic [PD_W-1:0] orig;
  } way_rec_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [PD_IDX_W-1:0] cfg_idx_i = '0;
  logic [PD_W-1:0]     cfg_data_i = '0;

  way_rec_t        way_shadow [0:N_SETS-1][0:N_WAYS-1];
  logic [PD_W-1:0] pd_shadow [0:NUM_PD_REGS-1];

  access_t      pending_accesses [$];
  reply_t       predicted_replies [$];
  access_t      on_bus;
  logic [9:0]   hot_sets [0:3];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_requests = 0;
  int unsigned  holds_served = 0;
  int unsigned  hold_left = 0;
  int unsigned  mismatches = 0;
  int unsigned  replies_seen = 0;
  int unsigned  items_queued = 0;
  int unsigned  invalid_victims = 0;
  int unsigned  valid_victims = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  op_count [0:3];

  protecting_distance_replacement #(
    .NUM_SETS     (N_SETS),
    .NUM_WAYS     (N_WAYS),
    .MAX_DISTANCE (MAX_DIST),
    .NUM_CPUS     (N_CPUS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow update for one access, returns the reply the block must give
  function automatic reply_t apply_to_ways(input access_t a);
    reply_t      rep;
    way_rec_t    r;
    logic [9:0]  best_d;
    bit          found;
    int          w;
    rep = '0;
    rep.done = 1'b1;
    case (a.op)
      OP_VICTIM: begin
        found = 1'b0;
        for (w = 0; w < N_WAYS; w++) begin
          if (!found && !way_shadow[a.set_idx][w].valid) begin
            rep.way = w[VICTIM_W-1:0];
            rep.was_invalid = 1'b1;
            found = 1'b1;
          end
        end
        if (!found) begin
          best_d = '0;
          for (w = 0; w < N_WAYS; w++) begin
            r = way_shadow[a.set_idx][w];
            if (!r.prot && r.rdist > best_d) begin
              best_d = r.rdist;
              rep.way = w[VICTIM_W-1:0];
              found = 1'b1;
            end
          end
          // no unprotected way with a nonzero distance: fall back to the largest distance overall
          if (!found) begin
            for (w = 0; w < N_WAYS; w++) begin
              r = way_shadow[a.set_idx][w];
              if (r.rdist > best_d) begin
                best_d = r.rdist;
                rep.way = w[VICTIM_W-1:0];
              end
            end
          end
        end
      end
      OP_HIT: begin
        r = way_shadow[a.set_idx][a.way];
        if (r.ip) begin
          r.prot = 1'b0;
        end else begin
          r.prot = 1'b1;
          r.rdist = {1'b0, r.orig};
          r.refb = 1'b1;
        end
        way_shadow[a.set_idx][a.way] = r;
      end
      OP_FILL: begin
        r = way_shadow[a.set_idx][a.way];
        r.valid = 1'b1;
        if (a.from_ip) begin
          r.ip = 1'b1;
          r.prot = 1'b1;
        end else begin
          r.ip = 1'b0;
          r.prot = 1'b0;
          r.rdist = {1'b0, pd_shadow[a.cpu]};
          r.orig = pd_shadow[a.cpu];
        end
        r.refb = 1'b0;
        way_shadow[a.set_idx][a.way] = r;
        // age the whole row, a counter at one or zero reloads
        for (w = 0; w < N_WAYS; w++) begin
          r = way_shadow[a.set_idx][w];
          if (r.rdist <= 10'd1) begin
            r.rdist = MAX_DIST[9:0] + {1'b0, r.orig};
            r.prot = 1'b0;
          end else begin
            r.rdist = r.rdist - 10'd1;
          end
          way_shadow[a.set_idx][w] = r;
        end
      end
      default: begin
        r = way_shadow[a.set_idx][a.way];
        r.valid = 1'b0;
        way_shadow[a.set_idx][a.way] = r;
      end
    endcase
    return rep;
  endfunction

  function automatic void queue_access(input opcode_e op, input logic [9:0] set_idx,
                                       input logic [3:0] way, input logic from_ip,
                                       input logic [1:0] cpu);
    access_t a;
    a.op      = op;
    a.set_idx = set_idx;
    a.way     = way;
    a.from_ip = from_ip;
    a.cpu     = cpu;
    pending_accesses.insert(pending_accesses.size(), a);
    items_queued = items_queued + 1;
  endfunction

  // mostly traffic on a few hot sets so rows fill up and age, some stray sets
  function automatic void queue_random_access();
    logic [9:0] set_idx;
    opcode_e    op;
    int unsigned k;
    if ($urandom_range(99) < 85) set_idx = hot_sets[2'($urandom_range(3))];
    else set_idx = 10'($urandom_range(N_SETS - 1));
    k = $urandom_range(99);
    if (k < 34) op = OP_FILL;
    else if (k < 60) op = OP_HIT;
    else if (k < 93) op = OP_VICTIM;
    else op = OP_INVAL;
    queue_access(op, set_idx, 4'($urandom_range(N_WAYS - 1)), ($urandom_range(3) == 0),
                 2'($urandom_range(N_CPUS - 1)));
  endfunction

  task automatic write_pd(input logic [PD_IDX_W-1:0] idx, input logic [PD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    pd_shadow[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_distances(input logic [PD_W-1:0] d0, input logic [PD_W-1:0] d1,
                                input logic [PD_W-1:0] d2, input logic [PD_W-1:0] d3);
    write_pd(PD_CPU0_IDX, d0);
    write_pd(PD_CPU1_IDX, d1);
    write_pd(PD_CPU2_IDX, d2);
    write_pd(PD_CPU3_IDX, d3);
  endtask

  // wait until every queued access has its reply; optionally stall the
  // receiver for a long stretch once half of the queue is gone
  task automatic drain(input bit long_hold);
    int unsigned half;
    bit asked;
    half  = pending_accesses.size() / 2;
    asked = 1'b0;
    while (replies_seen != items_queued) begin
      if (long_hold && !asked && pending_accesses.size() <= half) begin
        hold_requests = hold_requests + 1;
        asked = 1'b1;
      end
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.insert(predicted_replies.size(), apply_to_ways(on_bus));
        op_count[on_bus.op] = op_count[on_bus.op] + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_accesses.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, on_bus.cpu, on_bus.from_ip, on_bus.way, on_bus.set_idx};
          s_axis_tuser  <= on_bus.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen = replies_seen + 1;
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected transaction, tdata %h", $time, m_axis_tdata);
          mismatches = mismatches + 1;
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tdata[3:0] !== want.way) begin
            $display("%0t: victim_way expected %0d actual %0d", $time, want.way,
                     m_axis_tdata[3:0]);
            mismatches = mismatches + 1;
          end
          if (m_axis_tdata[4] !== want.was_invalid) begin
            $display("%0t: victim_was_invalid expected %0d actual %0d", $time,
                     want.was_invalid, m_axis_tdata[4]);
            mismatches = mismatches + 1;
          end
          if (m_axis_tdata[5] !== want.done) begin
            $display("%0t: op_done expected %0d actual %0d", $time, want.done,
                     m_axis_tdata[5]);
            mismatches = mismatches + 1;
          end
          if (want.was_invalid) invalid_victims = invalid_victims + 1;
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served = holds_served + 1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on transaction progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d replies outstanding", $time,
               idle_cycles, predicted_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int s;
    int w;
    int n;
    int phase;
    for (s = 0; s < N_SETS; s++)
      for (w = 0; w < N_WAYS; w++)
        way_shadow[s][w] = '0;
    for (s = 0; s < NUM_PD_REGS; s++) pd_shadow[s] = 9'd1;
    for (s = 0; s < 4; s++) op_count[s] = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_distances(9'd1, 9'd2, 9'd256, 9'd5);

    // directed: empty rows, zero counters on first aging, hit on an invalid
    // way, ip and cpu blocks, field extremes
    queue_access(OP_VICTIM, 10'd0, 4'd7, 1'b0, 2'd0);
    queue_access(OP_HIT, 10'd0, 4'd3, 1'b0, 2'd1);
    queue_access(OP_FILL, 10'd0, 4'd0, 1'b0, 2'd0);
    queue_access(OP_VICTIM, 10'd0, 4'd0, 1'b0, 2'd0);
    queue_access(OP_FILL, 10'd1023, 4'd15, 1'b1, 2'd3);
    queue_access(OP_VICTIM, 10'd1023, 4'd15, 1'b1, 2'd3);
    queue_access(OP_FILL, 10'd0, 4'd1, 1'b0, 2'd1);
    queue_access(OP_FILL, 10'd0, 4'd2, 1'b0, 2'd2);
    queue_access(OP_FILL, 10'd0, 4'd3, 1'b0, 2'd3);
    queue_access(OP_FILL, 10'd0, 4'd4, 1'b1, 2'd0);
    queue_access(OP_HIT, 10'd0, 4'd4, 1'b1, 2'd0);
    queue_access(OP_HIT, 10'd0, 4'd2, 1'b0, 2'd2);
    queue_access(OP_HIT, 10'd1023, 4'd15, 1'b0, 2'd3);
    queue_access(OP_VICTIM, 10'd0, 4'd0, 1'b0, 2'd0);
    queue_access(OP_INVAL, 10'd0, 4'd0, 1'b0, 2'd0);
    queue_access(OP_VICTIM, 10'd0, 4'd0, 1'b0, 2'd0);
    queue_access(OP_INVAL, 10'd1023, 4'd15, 1'b1, 2'd3);
    queue_access(OP_VICTIM, 10'd1023, 4'd0, 1'b0, 2'd0);
    queue_access(OP_FILL, 10'd512, 4'd8, 1'b0, 2'd2);
    queue_access(OP_VICTIM, 10'd512, 4'd8, 1'b0, 2'd2);
    drain(1'b0);

    for (phase = 0; phase < 4; phase++) begin
      hot_sets[0] = 10'd0;
      hot_sets[1] = 10'd1023;
      hot_sets[2] = 10'($urandom_range(N_SETS - 1));
      hot_sets[3] = 10'($urandom_range(N_SETS - 1));
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
          load_distances(9'd256, 9'd1, 9'd17, 9'd8);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
          load_distances(9'd0, 9'd511, 9'd4, 9'd256);
          // zero distance from cpu 0: fill a fresh row, then hit every way so
          // all counters sit at zero and the search falls back to way 0
          for (w = 0; w < N_WAYS; w++) queue_access(OP_FILL, 10'd5, 4'(w), 1'b0, 2'd0);
          for (w = 0; w < N_WAYS; w++) queue_access(OP_HIT, 10'd5, 4'(w), 1'b0, 2'd0);
          queue_access(OP_VICTIM, 10'd5, 4'd0, 1'b0, 2'd0);
        end
        default: begin
          send_idle_pct = 33;
          recv_stall_pct = 33;
          load_distances(9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)),
                         9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)));
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) queue_random_access();
      drain(phase == 1 || phase == 3);
    end

    mismatches = mismatches + predicted_replies.size();
    valid_victims = op_count[OP_VICTIM] - invalid_victims;
    $display("covered %0d accesses: %0d hits, %0d fills, %0d victim searches, %0d invalidates",
             replies_seen, op_count[OP_HIT], op_count[OP_FILL], op_count[OP_VICTIM],
             op_count[OP_INVAL]);
    $display("victims on invalid ways %0d, on valid ways %0d, long receiver holds %0d",
             invalid_victims, valid_victims, holds_served);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
